>>> hdl/gbpack_pkg.sv
// shared types and constants for the int8 gemm b panel packing core
package gbpack_pkg;

   // field widths
   localparam int ROW_W  = 12;
   localparam int COL_W  = 12;
   localparam int VAL_W  = 8;
   localparam int SUM_W  = 16;
   localparam int CFG_W  = 13;
   localparam int ADDR_W = 24;

   // column sum store
   localparam int MAX_COLS = 4096;
   localparam int MEM_AW   = $clog2(MAX_COLS);

   // panel geometry: full panels 32 wide, fringe panels 16 wide
   localparam int PANEL_WIDTH = 32;
   localparam int PANEL_SH    = $clog2(PANEL_WIDTH);
   localparam int FRINGE_SH   = PANEL_SH - 1;

   // derived datapath widths
   localparam int KC_W   = CFG_W + 1;
   localparam int PROD_W = COL_W + KC_W;
   localparam int OFF_W  = ROW_W - 1 + PANEL_SH + 1;

   // register reset values
   localparam logic [CFG_W-1:0] NUM_COLS_RESET = CFG_W'(32);
   localparam logic [CFG_W-1:0] NUM_ROWS_RESET = CFG_W'(2);

   typedef enum logic [0:0] {
      CSR_NUM_COLS = 1'b0,
      CSR_NUM_ROWS = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_PACK    = 1'b0,
      OP_PRELOAD = 1'b1
   } opcode_type;

endpackage

>>> hdl/int8_gemm_b_pack_colsum_core.sv
// top level of the int8 gemm b panel packing core with column sums
//
//   channel  direction  handshake               carries
//   req_     in         req_valid / req_stall    opcode, row, column, element, preload sum
//   rsp_     out        rsp_valid / rsp_stall    byte address, byte value, column sum, pad, last
//   csr_     in         csr_valid / csr_ready    register index, write data
//
// one request per cycle while req_stall is low: the sum ram is read at accept
// and written back as the request leaves stage 1, with the last write
// forwarded to the request behind it; a pack result passes the stage 1,
// stage 2 and output registers, and the last row of an odd row count adds a pad byte
// after reset all 4096 sum ram entries are swept to zero with req_stall high
// csr writes are always taken; rsp_stall backs up combinationally to req_stall
module int8_gemm_b_pack_colsum_core import gbpack_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [ROW_W-1:0]         req_row_index,
   input  logic [COL_W-1:0]         req_col_index,
   input  logic signed [VAL_W-1:0]  req_element_value,
   input  logic signed [SUM_W-1:0]  req_preload_sum,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ADDR_W-1:0]        rsp_byte_address,
   output logic signed [VAL_W-1:0]  rsp_byte_value,
   output logic signed [SUM_W-1:0]  rsp_column_sum,
   output logic                     rsp_is_pad,
   output logic                     rsp_last,
   // configuration channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [0:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_wdata
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] num_cols_ff, num_cols_in;
   logic [CFG_W-1:0] num_rows_ff, num_rows_in;

   assign csr_ready = 1'b1;

   always_comb begin
      num_cols_in = num_cols_ff;
      num_rows_in = num_rows_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_COLS: num_cols_in = csr_wdata;
            CSR_NUM_ROWS: num_rows_in = csr_wdata;
            default:      num_cols_in = num_cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= NUM_COLS_RESET;
         num_rows_ff <= NUM_ROWS_RESET;
      end else begin
         num_cols_ff <= num_cols_in;
         num_rows_ff <= num_rows_in;
      end
   end

   // ------------------------------------------------------------------
   // flow control
   // ------------------------------------------------------------------
   logic clr_active_ff, clr_active_in;
   logic [MEM_AW-1:0] clr_idx_ff, clr_idx_in;

   logic s1_valid_ff, s1_valid_in;
   opcode_type s1_op_ff, s1_op_in;
   logic [ROW_W-1:0] s1_row_ff, s1_row_in;
   logic [COL_W-1:0] s1_col_ff, s1_col_in;
   logic [VAL_W-1:0] s1_val_ff, s1_val_in;
   logic [SUM_W-1:0] s1_pre_ff, s1_pre_in;

   logic s2_valid_ff, s2_valid_in;
   logic [PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [OFF_W-1:0] s2_off_ff, s2_off_in;
   logic [VAL_W-1:0] s2_val_ff, s2_val_in;
   logic [SUM_W-1:0] s2_sum_ff, s2_sum_in;
   logic s2_pad_ff, s2_pad_in;

   logic out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [VAL_W-1:0] out_val_ff, out_val_in;
   logic [SUM_W-1:0] out_sum_ff, out_sum_in;
   logic out_pad_ff, out_pad_in;
   logic out_last_ff, out_last_in;

   logic req_accept, rsp_accept;
   logic out_free, s2_free, s1_done, s1_free, s2_load, out_next_pad;

   assign rsp_accept   = rsp_valid && !rsp_stall;
   assign out_free     = !out_valid_ff || (rsp_accept && out_last_ff);
   assign out_next_pad = rsp_accept && !out_last_ff;
   assign s2_free      = !s2_valid_ff || out_free;
   // a preload only writes the ram and never needs the later stages
   assign s1_done      = s1_valid_ff && ((s1_op_ff == OP_PRELOAD) || s2_free);
   assign s1_free      = !s1_valid_ff || s1_done;
   assign s2_load      = s1_done && (s1_op_ff == OP_PACK);
   assign req_stall    = clr_active_ff || !s1_free;
   assign req_accept   = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // column sum ram, clearing sweep and write forwarding
   // ------------------------------------------------------------------
   logic              ram_wr_en;
   logic [MEM_AW-1:0] ram_wr_addr;
   logic [SUM_W-1:0]  ram_wr_data;
   logic [SUM_W-1:0]  ram_rd_data;

   // last word written, kept until the next write
   logic              wr_valid_ff, wr_valid_in;
   logic [MEM_AW-1:0] wr_addr_ff, wr_addr_in;
   logic [SUM_W-1:0]  wr_data_ff, wr_data_in;

   logic [SUM_W-1:0] sum_base;
   logic [SUM_W-1:0] sum_addend;
   logic [SUM_W-1:0] sum_new;

   gbpack_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_COLS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_col_index[MEM_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // the ram returns old data when read and written together, and outside the clearing sweep
   // the sum stage is the only writer, so the last write covers every overlap
   assign sum_base   = (wr_valid_ff && (wr_addr_ff == s1_col_ff[MEM_AW-1:0]))
                     ? wr_data_ff : ram_rd_data;
   // 128 times the sign extended element, modulo 2^16
   assign sum_addend = {s1_val_ff[VAL_W-1], s1_val_ff, {(SUM_W-VAL_W-1){1'b0}}};
   assign sum_new    = sum_base + sum_addend;

   always_comb begin
      ram_wr_en   = clr_active_ff || s1_done;
      ram_wr_addr = clr_active_ff ? clr_idx_ff : s1_col_ff[MEM_AW-1:0];
      priority if (clr_active_ff) begin
         ram_wr_data = '0;
      end else if (s1_op_ff == OP_PRELOAD) begin
         ram_wr_data = s1_pre_ff;
      end else begin
         ram_wr_data = sum_new;
      end
      wr_valid_in = wr_valid_ff || ram_wr_en;
      wr_addr_in  = ram_wr_en ? ram_wr_addr : wr_addr_ff;
      wr_data_in  = ram_wr_en ? ram_wr_data : wr_data_ff;
      // sweep every entry once after reset
      clr_active_in = clr_active_ff && !(&clr_idx_ff);
      clr_idx_in    = clr_active_ff ? clr_idx_ff + MEM_AW'(1) : clr_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         wr_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         wr_valid_ff   <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
   end

   // ------------------------------------------------------------------
   // stage 1: request registers, sum update, panel address product
   // ------------------------------------------------------------------
   logic [CFG_W-1:0]    full_cols;
   logic                in_full;
   logic [PANEL_SH-1:0] lc;
   logic [COL_W-1:0]    col_base;
   logic [KC_W-1:0]     kc;
   logic [OFF_W-1:0]    row_term;
   logic                pad_needed;

   always_comb begin
      s1_valid_in = req_accept || (s1_valid_ff && !s1_done);
      s1_op_in    = req_accept ? opcode_type'(req_opcode) : s1_op_ff;
      s1_row_in   = req_accept ? req_row_index : s1_row_ff;
      s1_col_in   = req_accept ? req_col_index : s1_col_ff;
      s1_val_in   = req_accept ? req_element_value : s1_val_ff;
      s1_pre_in   = req_accept ? req_preload_sum : s1_pre_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= s1_op_in;
      s1_row_ff <= s1_row_in;
      s1_col_ff <= s1_col_in;
      s1_val_ff <= s1_val_in;
      s1_pre_ff <= s1_pre_in;
   end

   always_comb begin
      // columns below a multiple of 32 sit in full panels
      full_cols = {num_cols_ff[CFG_W-1:PANEL_SH], {PANEL_SH{1'b0}}};
      in_full   = CFG_W'(s1_col_ff) < full_cols;
      // fringe panels start on a multiple of 16, so their lane is the low bits
      lc        = in_full ? s1_col_ff[PANEL_SH-1:0]
                          : PANEL_SH'(s1_col_ff[FRINGE_SH-1:0]);
      col_base  = s1_col_ff - COL_W'(lc);
      // row count rounded up to even
      kc        = KC_W'(num_rows_ff) + KC_W'(num_rows_ff[0]);
      row_term  = in_full ? OFF_W'({s1_row_ff[ROW_W-1:1], {(PANEL_SH+1){1'b0}}})
                          : OFF_W'({s1_row_ff[ROW_W-1:1], {(FRINGE_SH+1){1'b0}}});
      pad_needed = num_rows_ff[0] && ((CFG_W'(s1_row_ff) + CFG_W'(1)) == num_rows_ff);

      s2_valid_in = s2_load || (s2_valid_ff && !out_free);
      s2_prod_in  = s2_load ? PROD_W'(col_base) * PROD_W'(kc) : s2_prod_ff;
      s2_off_in   = s2_load ? row_term + OFF_W'({lc, 1'b0}) + OFF_W'(s1_row_ff[0])
                            : s2_off_ff;
      s2_val_in   = s2_load ? s1_val_ff : s2_val_ff;
      s2_sum_in   = s2_load ? sum_new : s2_sum_ff;
      s2_pad_in   = s2_load ? pad_needed : s2_pad_ff;
   end

   // ------------------------------------------------------------------
   // stage 2: registered product and in-panel offset
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_prod_ff <= s2_prod_in;
      s2_off_ff  <= s2_off_in;
      s2_val_ff  <= s2_val_in;
      s2_sum_ff  <= s2_sum_in;
      s2_pad_ff  <= s2_pad_in;
   end

   // ------------------------------------------------------------------
   // output register: element result, then the pad byte when needed
   // ------------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_val_in   = out_val_ff;
      out_sum_in   = out_sum_ff;
      out_pad_in   = out_pad_ff;
      out_last_in  = out_last_ff;
      priority if (out_free) begin
         out_valid_in = s2_valid_ff;
         out_addr_in  = s2_prod_ff[ADDR_W-1:0] + ADDR_W'(s2_off_ff);
         out_val_in   = s2_val_ff;
         out_sum_in   = s2_sum_ff;
         out_pad_in   = 1'b0;
         out_last_in  = !s2_pad_ff;
      end else if (out_next_pad) begin
         // pad byte sits right after the element, same column sum
         out_addr_in  = out_addr_ff + ADDR_W'(1);
         out_val_in   = '0;
         out_pad_in   = 1'b1;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_addr_ff <= out_addr_in;
      out_val_ff  <= out_val_in;
      out_sum_ff  <= out_sum_in;
      out_pad_ff  <= out_pad_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_byte_value   = out_val_ff;
   assign rsp_column_sum   = out_sum_ff;
   assign rsp_is_pad       = out_pad_ff;
   assign rsp_last         = out_last_ff;

endmodule

>>> hdl/gbpack_ram.sv
// generic single write port, single read port ram with registered read
module gbpack_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gbpack_checker.sv
// port level checks for the packing core, bound to its top level
module gbpack_checker import gbpack_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [ADDR_W-1:0]        rsp_byte_address,
   input logic signed [VAL_W-1:0]  rsp_byte_value,
   input logic signed [SUM_W-1:0]  rsp_column_sum,
   input logic                     rsp_is_pad,
   input logic                     rsp_last
);

   // the clearing sweep holds requests off right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("requests not held off after reset");

   // a pad byte always ends its request and carries zero
   a_pad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_pad) |-> (rsp_last && (rsp_byte_value == '0)))
      else $error("pad byte not last or not zero");

   // a taken element result that is not last is followed by its pad byte
   a_pad_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         (rsp_valid && rsp_is_pad && $stable(rsp_column_sum)
          && (rsp_byte_address == $past(rsp_byte_address) + ADDR_W'(1))))
      else $error("pad byte missing or misplaced");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_byte_address) && $stable(rsp_column_sum)
          && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind int8_gemm_b_pack_colsum_core gbpack_checker u_gbpack_checker (.*);

>>> verif/tb_int8_gemm_b_pack_colsum_core.sv
// testbench for the int8 gemm b panel packing core: directed and random packing with column sums
`timescale 1ns / 100ps

// one result of a pack request, as the core should emit it
typedef struct packed {
   logic [gbpack_pkg::ADDR_W-1:0]        byte_address;
   logic signed [gbpack_pkg::VAL_W-1:0]  byte_value;
   logic signed [gbpack_pkg::SUM_W-1:0]  column_sum;
   logic                                 is_pad;
   logic                                 last;
} packed_byte_type;

// shadow of the column sums and registers, plus the queue of bytes still owed
class panel_pack_board_type;
   logic [gbpack_pkg::SUM_W-1:0] sum_shadow [gbpack_pkg::MAX_COLS];
   logic [gbpack_pkg::CFG_W-1:0] num_cols;
   logic [gbpack_pkg::CFG_W-1:0] num_rows;
   packed_byte_type              owed_bytes [$];
   int unsigned                  mismatches;

   function new();
      foreach (sum_shadow[i]) sum_shadow[i] = '0;
      num_cols   = gbpack_pkg::NUM_COLS_RESET;
      num_rows   = gbpack_pkg::NUM_ROWS_RESET;
      mismatches = 0;
   endfunction

   function int unsigned pending();
      return owed_bytes.size();
   endfunction

   function void note_config(input logic [0:0] index, input logic [gbpack_pkg::CFG_W-1:0] data);
      unique case (gbpack_pkg::csr_index_type'(index))
         gbpack_pkg::CSR_NUM_COLS: num_cols = data;
         gbpack_pkg::CSR_NUM_ROWS: num_rows = data;
         default: ;
      endcase
   endfunction

   // byte offset of element (row, col) in the k2-interleaved panel layout
   function longint unsigned panel_offset(input longint unsigned row, input longint unsigned col);
      longint unsigned kc, full_cols, width, lc;
      kc        = num_rows + (num_rows & 1);
      full_cols = (num_cols / gbpack_pkg::PANEL_WIDTH) * gbpack_pkg::PANEL_WIDTH;
      if (col < full_cols) begin
         width = gbpack_pkg::PANEL_WIDTH;
         lc    = col % gbpack_pkg::PANEL_WIDTH;
      end else begin
         // leftover columns fall into half-width fringe panels
         width = gbpack_pkg::PANEL_WIDTH / 2;
         lc    = (col - full_cols) % (gbpack_pkg::PANEL_WIDTH / 2);
      end
      return (col - lc) * kc + 2 * width * (row >> 1) + 2 * lc + (row & 1);
   endfunction

   function void note_request(input gbpack_pkg::opcode_type op,
                              input logic [gbpack_pkg::ROW_W-1:0] row,
                              input logic [gbpack_pkg::COL_W-1:0] col,
                              input logic signed [gbpack_pkg::VAL_W-1:0] val,
                              input logic signed [gbpack_pkg::SUM_W-1:0] preload);
      logic [gbpack_pkg::SUM_W-1:0] sum;
      longint unsigned              addr;
      bit                           pad;
      packed_byte_type              item;
      if (op == gbpack_pkg::OP_PRELOAD) begin
         sum_shadow[col] = preload;
         return;
      end
      // 128 * value, sign extended to 16 bits; the sum wraps
      sum             = sum_shadow[col] + {val[7], val, 7'b0};
      sum_shadow[col] = sum;
      addr = panel_offset(64'(row), 64'(col));
      pad  = num_rows[0] && (longint'(row) + 1 == longint'(num_rows));
      item.byte_address = addr[gbpack_pkg::ADDR_W-1:0];
      item.byte_value   = val;
      item.column_sum   = sum;
      item.is_pad       = 1'b0;
      item.last         = !pad;
      owed_bytes.push_back(item);
      if (pad) begin
         addr              = addr + 1;
         item.byte_address = addr[gbpack_pkg::ADDR_W-1:0];
         item.byte_value   = '0;
         item.is_pad       = 1'b1;
         item.last         = 1'b1;
         owed_bytes.push_back(item);
      end
   endfunction

   function void report(input string field, input longint unsigned want, input longint unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
   endfunction

   function void check_result(input packed_byte_type got);
      packed_byte_type want;
      if (owed_bytes.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result, expected none got address %0h", $time,
                  got.byte_address);
         return;
      end
      want = owed_bytes.pop_front();
      if (got.byte_address !== want.byte_address)
         report("byte_address", 64'(want.byte_address), 64'(got.byte_address));
      if (got.byte_value !== want.byte_value)
         report("byte_value", 64'(unsigned'(want.byte_value)), 64'(unsigned'(got.byte_value)));
      if (got.column_sum !== want.column_sum)
         report("column_sum", 64'(unsigned'(want.column_sum)), 64'(unsigned'(got.column_sum)));
      if (got.is_pad !== want.is_pad)
         report("is_pad", 64'(want.is_pad), 64'(got.is_pad));
      if (got.last !== want.last)
         report("last", 64'(want.last), 64'(got.last));
   endfunction
endclass

module tb_int8_gemm_b_pack_colsum_core import gbpack_pkg::*;;

   // no-accept cycles allowed: the sum clear after reset plus the longest
   // stall and gap, taken several times over
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   // cycles allowed after the last result before a register write, so a
   // preload still in the pipe lands first
   localparam int unsigned SETTLE_CYCLES  = 10;

   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic                    req_opcode        = OP_PACK;
   logic [ROW_W-1:0]        req_row_index     = '0;
   logic [COL_W-1:0]        req_col_index     = '0;
   logic signed [VAL_W-1:0] req_element_value = '0;
   logic signed [SUM_W-1:0] req_preload_sum   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic [ADDR_W-1:0]       rsp_byte_address;
   logic signed [VAL_W-1:0] rsp_byte_value;
   logic signed [SUM_W-1:0] rsp_column_sum;
   logic                    rsp_is_pad;
   logic                    rsp_last;
   logic                    csr_valid         = 1'b0;
   logic                    csr_ready;
   logic [0:0]              csr_index         = '0;
   logic [CFG_W-1:0]        csr_wdata         = '0;

   panel_pack_board_type board;
   bit              no_idle      = 1'b0;
   int unsigned     sink_run     = 0;
   int unsigned     quiet_cycles = 0;
   logic [CFG_W-1:0] cur_cols    = NUM_COLS_RESET;
   logic [CFG_W-1:0] cur_rows    = NUM_ROWS_RESET;

   int8_gemm_b_pack_colsum_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .req_preload_sum   (req_preload_sum),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_column_sum    (rsp_column_sum),
      .rsp_is_pad        (rsp_is_pad),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // register value: extremes and edge values, random ones, or a random odd one
   function automatic logic [CFG_W-1:0] pick_dimension();
      unique case ($urandom_range(0, 9))
         0: return CFG_W'(1);
         1: return CFG_W'(0);
         2: return CFG_W'(8191);
         3: return CFG_W'(4096);
         4: return CFG_W'(32);
         5: return CFG_W'(33);
         6: return CFG_W'(3);
         7: return CFG_W'($urandom_range(1, 64));
         8: return CFG_W'($urandom_range(0, 8191));
         default: return CFG_W'($urandom_range(0, 40) * 2 + 1);
      endcase
   endfunction

   // result side: alternate free runs and stall runs of random length
   always @(posedge clock) begin
      if (no_idle) begin
         rsp_stall <= 1'b0;
         sink_run  <= 0;
      end else if (sink_run != 0) begin
         sink_run <= sink_run - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         sink_run  <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b1;
         sink_run  <= pick_gap();
      end
   end

   // monitor: results are checked before requests of the same edge are noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result('{rsp_byte_address, rsp_byte_value, rsp_column_sum,
                                 rsp_is_pad, rsp_last});
         if (csr_valid && csr_ready)
            board.note_config(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            board.note_request(opcode_type'(req_opcode), req_row_index, req_col_index,
                               req_element_value, req_preload_sum);
      end
   end

   // watchdog on cycles in which no channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_int8_gemm_b_pack_colsum_core: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one request and hold it until the core takes it
   task automatic send_request(input opcode_type op, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col, input logic signed [VAL_W-1:0] val,
                               input logic signed [SUM_W-1:0] preload);
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_row_index     <= row;
      req_col_index     <= col;
      req_element_value <= val;
      req_preload_sum   <= preload;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid for a gap of n; n of zero keeps the request stream back to back
   task automatic idle_gap(input int unsigned n);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop sending until every owed byte has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // idle the core, then write both registers
   task automatic set_config(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_NUM_COLS;
      csr_wdata <= cols;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_NUM_ROWS;
      csr_wdata <= rows;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_cols  = cols;
      cur_rows  = rows;
   endtask

   // random requests under the current register setting
   task automatic random_phase(input int unsigned items, input bit quiet);
      int unsigned      max_row, max_col, col_base, kind, col_off;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      no_idle <= quiet;
      max_row  = (cur_rows == 0 || cur_rows > 4096) ? 4095 : cur_rows - 1;
      max_col  = (cur_cols == 0) ? 63 : ((cur_cols > 4096) ? 4095 : cur_cols - 1);
      col_base = $urandom_range(0, max_col);
      for (int unsigned i = 0; i < items; i++) begin
         kind = $urandom_range(0, 99);
         // well-formed coordinates, last row favored so pad bytes show up
         row = ROW_W'(($urandom_range(0, 3) == 0) ? max_row : $urandom_range(0, max_row));
         // a narrow window of columns makes the sums build up and collide
         col_off = $urandom_range(0, 7);
         if ($urandom_range(0, 1) == 0)
            col = COL_W'((col_base + col_off > max_col) ? max_col : col_base + col_off);
         else
            col = COL_W'($urandom_range(0, max_col));
         if (kind < 10) begin
            send_request(OP_PRELOAD, ROW_W'($urandom_range(0, 4095)), col,
                         VAL_W'($urandom_range(0, 255)), SUM_W'($urandom_range(0, 65535)));
         end else if (kind < 25) begin
            // noise: anywhere in the field ranges
            send_request(OP_PACK, ROW_W'($urandom_range(0, 4095)),
                         COL_W'($urandom_range(0, 4095)), VAL_W'($urandom_range(0, 255)),
                         SUM_W'($urandom_range(0, 65535)));
         end else begin
            send_request(OP_PACK, row, col, VAL_W'($urandom_range(0, 255)),
                         SUM_W'($urandom_range(0, 65535)));
         end
         if ($urandom_range(0, 63) == 0)
            wait_drained();
         else
            idle_gap(pick_gap());
      end
      no_idle <= 1'b0;
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset setting: 32 columns, 2 rows
      send_request(OP_PACK, 12'd0, 12'd0, -8'sd128, 16'sd0);
      send_request(OP_PACK, 12'd1, 12'd0, 8'sd127, 16'sd0);
      send_request(OP_PACK, 12'd1, 12'd31, -8'sd1, 16'sd0);
      // first fringe column
      send_request(OP_PACK, 12'd0, 12'd32, 8'sd1, 16'sd0);
      // row and column far beyond the setting
      send_request(OP_PACK, 12'd4095, 12'd4095, 8'sd0, 16'sd0);
      // preload then pack right behind it, wrapping both ways
      send_request(OP_PRELOAD, 12'd0, 12'd7, 8'sd0, 16'sd32767);
      send_request(OP_PACK, 12'd0, 12'd7, 8'sd1, 16'sd0);
      send_request(OP_PRELOAD, 12'd0, 12'd8, 8'sd0, -16'sd32768);
      send_request(OP_PACK, 12'd1, 12'd8, -8'sd1, 16'sd0);
      wait_drained();

      // largest registers: the address wraps past 24 bits
      set_config(CFG_W'(8191), CFG_W'(8191));
      send_request(OP_PACK, 12'd4095, 12'd4095, 8'sd127, 16'sd0);
      send_request(OP_PACK, 12'd0, 12'd4064, -8'sd128, 16'sd0);

      // one column, one row: pad byte on row zero, fringe beyond the column
      set_config(CFG_W'(1), CFG_W'(1));
      send_request(OP_PACK, 12'd0, 12'd0, 8'sd5, 16'sd0);
      send_request(OP_PACK, 12'd0, 12'd1, -8'sd3, 16'sd0);
      send_request(OP_PACK, 12'd1, 12'd0, 8'sd9, 16'sd0);

      // zero columns and rows: all fringe, zero panel depth
      set_config(CFG_W'(0), CFG_W'(0));
      send_request(OP_PACK, 12'd3, 12'd17, -8'sd7, 16'sd0);
      send_request(OP_PACK, 12'd0, 12'd0, 8'sd64, 16'sd0);

      // 4096 columns, odd depth: pad on the last row, none past it
      set_config(CFG_W'(4096), CFG_W'(4095));
      send_request(OP_PACK, 12'd4094, 12'd4095, 8'sd127, 16'sd0);
      send_request(OP_PACK, 12'd4095, 12'd0, -8'sd2, 16'sd0);

      set_config(CFG_W'(33), CFG_W'(4096));
      send_request(OP_PACK, 12'd4095, 12'd32, -8'sd128, 16'sd0);

      // random part: first phase runs without idling on either side
      set_config(CFG_W'(64), CFG_W'(5));
      random_phase(85, 1'b1);
      for (int unsigned p = 0; p < 5; p++) begin
         set_config(pick_dimension(), pick_dimension());
         random_phase(85, 1'b0);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb_int8_gemm_b_pack_colsum_core: PASS");
      else
         $display("tb_int8_gemm_b_pack_colsum_core: FAIL");
      $finish;
   end

endmodule
